/* rtl/core/iols_pkg.sv */
`default_nettype none

package iols_pkg;

    // Widths fixed by the word formats.
    localparam int DATA_W     = 32;
    localparam int POS_W      = 7;
    localparam int MODE_W     = 3;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 7;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 48;

    // Default number of entries in the store.
    localparam int CAPACITY_DEF = 64;

    // Operation codes carried in s_tuser.
    localparam logic [MODE_W-1:0] MODE_GET         = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT_AT   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INSERT_HEAD = 3'd2;
    localparam logic [MODE_W-1:0] MODE_INSERT_TAIL = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DELETE_AT   = 3'd4;

    // Status codes returned with every result word.
    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // Operation broadcast along the row of cells.
    typedef enum logic [1:0] {
        CO_NONE,
        CO_READ,
        CO_INSERT,
        CO_DELETE
    } cell_op_t;

    typedef struct packed {
        logic     en;
        cell_op_t op;
    } cell_cmd_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WRITE
    } state_t;

endpackage

`default_nettype wire

/* rtl/core/iols_cell.sv */
`default_nettype none

module iols_cell
    import iols_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CMP_W = POS_W
) (
    input  wire logic              aclk,
    input  wire cell_cmd_t         cmd,
    input  wire logic [CMP_W-1:0]  pos,
    input  wire logic [DATA_W-1:0] value,
    input  wire logic [DATA_W-1:0] lower_entry,
    input  wire logic [DATA_W-1:0] upper_entry,
    output logic      [DATA_W-1:0] entry,
    output logic      [DATA_W-1:0] read_data
);

    logic [DATA_W-1:0] entry_reg;
    logic [DATA_W-1:0] read_reg;
    logic              at_pos;
    logic              above_pos;

    // Where this cell sits relative to the operation's position.
    assign at_pos    = (CMP_W'(INDEX) == pos);
    assign above_pos = (CMP_W'(INDEX) >  pos);

    // Insert pulls from the cell below, delete pulls from the cell above.
    always_ff @(posedge aclk) begin
        if (cmd.en) begin
            unique case (cmd.op)
                CO_INSERT: begin
                    if (above_pos) begin
                        entry_reg <= lower_entry;
                    end else if (at_pos) begin
                        entry_reg <= value;
                    end
                end
                CO_DELETE: begin
                    if (above_pos || at_pos) begin
                        entry_reg <= upper_entry;
                    end
                end
                default: begin
                end
            endcase
            // Only the addressed cell offers its entry to the read OR.
            read_reg <= (cmd.op == CO_READ && at_pos) ? entry_reg : '0;
        end
    end

    assign entry     = entry_reg;
    assign read_data = read_reg;

endmodule

`default_nettype wire

/* rtl/core/indexed_ordered_list_store.sv */
// An accepted word is registered, steps the cell row in ST_EXEC, and its result enters
// the output register in ST_WRITE once free; the sequencer takes one word at a time
// (decode, one shift step of the cell row, then the read OR into the output register).
// A new word is taken while the previous result still waits on the output register.
// Reset (aresetn low, synchronous) empties the list and clears the handshake state;
// entry contents are not cleared and are never read before they are written.
`default_nettype none

module indexed_ordered_list_store
    import iols_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [6:0] position, [38:7] value, [39] zero
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // [2:0] mode
    input  wire logic [MODE_W-1:0]    s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [31:0] read_value, [33:32] status, [40:34] entry_count, [47:41] zero
    output logic      [M_TDATA_W-1:0] m_tdata
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg;
    cell_op_t              op_reg;
    logic [CMP_W-1:0]      pos_reg;
    logic [DATA_W-1:0]     value_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic                  miss_reg;
    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;

    logic                  accept;
    logic                  exec_en;
    logic                  out_load;
    cell_op_t              op_dec;
    logic [CMP_W-1:0]      pos_dec;
    logic [STATUS_W-1:0]   status_dec;
    logic                  miss_dec;
    logic [CMP_W-1:0]      pos_in;
    logic [CMP_W-1:0]      count_ext;
    logic                  full;
    logic [MODE_W-1:0]     mode_in;
    cell_cmd_t             cmd;
    logic [DATA_W-1:0]     entries   [CAPACITY];
    logic [DATA_W-1:0]     read_bits [CAPACITY];
    logic [DATA_W-1:0]     read_or;
    logic [DATA_W-1:0]     read_value;

    assign mode_in   = s_tuser;
    assign pos_in    = CMP_W'(s_tdata[POS_W-1:0]);
    assign count_ext = CMP_W'(count_reg);
    assign full      = (count_reg == CNT_W'(CAPACITY));

    // Decode the operation against the current count.
    always_comb begin
        op_dec     = CO_NONE;
        pos_dec    = pos_in;
        status_dec = STATUS_DONE;
        miss_dec   = 1'b0;
        unique case (mode_in)
            MODE_GET: begin
                if (pos_in < count_ext) begin
                    op_dec = CO_READ;
                end else begin
                    status_dec = STATUS_RANGE;
                    miss_dec   = 1'b1;
                end
            end
            MODE_INSERT_AT: begin
                if (pos_in > count_ext) begin
                    status_dec = STATUS_RANGE;
                end else if (full) begin
                    status_dec = STATUS_FULL;
                end else begin
                    op_dec = CO_INSERT;
                end
            end
            MODE_INSERT_HEAD: begin
                pos_dec = '0;
                if (full) begin
                    status_dec = STATUS_FULL;
                end else begin
                    op_dec = CO_INSERT;
                end
            end
            MODE_INSERT_TAIL: begin
                pos_dec = count_ext;
                if (full) begin
                    status_dec = STATUS_FULL;
                end else begin
                    op_dec = CO_INSERT;
                end
            end
            MODE_DELETE_AT: begin
                if (pos_in < count_ext) begin
                    op_dec = CO_DELETE;
                end else begin
                    status_dec = STATUS_RANGE;
                end
            end
            default: begin
            end
        endcase
    end

    // Sequencer: take a word, step the cell row, then write the result.
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        exec_en    = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                exec_en    = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Decoded operation held for the execute step.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg <= CO_NONE;
        end else if (accept) begin
            op_reg <= op_dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pos_reg    <= pos_dec;
            value_reg  <= s_tdata[POS_W +: DATA_W];
            status_reg <= status_dec;
            miss_reg   <= miss_dec;
        end
    end

    // Entry count follows the shift direction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (exec_en) begin
            if (op_reg == CO_INSERT) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (op_reg == CO_DELETE) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    assign cmd.en = exec_en;
    assign cmd.op = op_reg;

    // Row of cells, one entry each, linked to both neighbours.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_W-1:0] lower_entry;
        logic [DATA_W-1:0] upper_entry;

        if (i == 0) begin : g_first
            assign lower_entry = value_reg;
        end else begin : g_lower
            assign lower_entry = entries[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign upper_entry = entries[i];
        end else begin : g_upper
            assign upper_entry = entries[i+1];
        end

        iols_cell #(
            .INDEX (i),
            .CMP_W (CMP_W)
        ) u_cell (
            .aclk        (aclk),
            .cmd         (cmd),
            .pos         (pos_reg),
            .value       (value_reg),
            .lower_entry (lower_entry),
            .upper_entry (upper_entry),
            .entry       (entries[i]),
            .read_data   (read_bits[i])
        );
    end

    // At most one cell offers a non-zero read word, so an OR collects it.
    always_comb begin
        read_or = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            read_or = read_or | read_bits[i];
        end
    end

    always_comb begin
        if (op_reg == CO_READ) begin
            read_value = read_or;
        end else if (miss_reg) begin
            read_value = '1;
        end else begin
            read_value = '0;
        end
    end

    // Output register parts the result from the next operation.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {(M_TDATA_W - DATA_W - STATUS_W - COUNT_W)'(0),
                            count_ext[COUNT_W-1:0], status_reg, read_value};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The list never holds more than its capacity.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // A performed insert grows the list by one.
    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec_en && op_reg == CO_INSERT) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the list");

    // A performed delete shrinks the list by one.
    a_delete_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec_en && op_reg == CO_DELETE) |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("delete did not shrink the list");

    // A result loaded from the write step is presented next cycle.
    a_result_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_tvalid)
        else $error("result word not presented");

endmodule

`default_nettype wire
